// ===== hw/rtl/bilinear_height_sampler_top_defines.svh =====
// Assertion macros for the bilinear height sampler checker.
// Plain text macros only; no dependencies.
`ifndef BILINEAR_HEIGHT_SAMPLER_TOP_DEFINES_SVH
`define BILINEAR_HEIGHT_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbs check failed");

`endif

// ===== hw/rtl/hbs_pkg.sv =====
// Shared types and constants for the bilinear height sampler.
// No dependencies; the files that use it refer to it by scoped names.
package hbs_pkg;

    localparam int H_W        = 24;   // height, Q16.8
    localparam int POS_W      = 24;   // query position, Q16.8
    localparam int SCALE_W    = 24;   // inverse world scale, Q8.16
    localparam int GRID_W     = 9;    // grid width / depth registers
    localparam int WIDX_W     = 8;    // write column / row fields
    localparam int FRAC_W     = 40;   // fraction, Q.16, may extrapolate
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WORLD_SCALE = 2'd2;

    localparam logic [GRID_W-1:0]  GRID_RESET  = 9'd256;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic signed [H_W-1:0] H_MAX = 24'sh7FFFFF;
    localparam logic signed [H_W-1:0] H_MIN = 24'sh800000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COORD,
        ST_RD00,
        ST_RD10,
        ST_RD01,
        ST_RD11,
        ST_CAP,
        ST_BSTART,
        ST_BWAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        BL_ROW0,
        BL_ROW1,
        BL_COL
    } t_bsel;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_X,
        CS_Z,
        CS_DONE
    } t_cstep;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_LO,
        BS_HI,
        BS_ADD,
        BS_DONE
    } t_bstep;

    // Corner status of one axis
    typedef struct packed {
        logic                     lo_ok;
        logic                     hi_ok;
        logic signed [FRAC_W-1:0] frac;
    } t_axis;

endpackage

// ===== hw/rtl/hbs_if.sv =====
// Channel interfaces of the bilinear height sampler: input items, results,
// configuration writes. Depends on hbs_pkg for field widths.
interface hbs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [hbs_pkg::WIDX_W-1:0]          write_col;
    logic [hbs_pkg::WIDX_W-1:0]          write_row;
    logic signed [hbs_pkg::H_W-1:0]      write_height;
    logic signed [hbs_pkg::POS_W-1:0]    query_x;
    logic signed [hbs_pkg::POS_W-1:0]    query_z;

    modport source (output valid, operation, write_col, write_row, write_height,
                    query_x, query_z, input ready);
    modport sink   (input valid, operation, write_col, write_row, write_height,
                    query_x, query_z, output ready);
endinterface

interface hbs_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [hbs_pkg::H_W-1:0] sampled_height;

    modport source (output valid, sampled_height, input ready);
    modport sink   (input valid, sampled_height, output ready);
endinterface

interface hbs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [hbs_pkg::CFG_IDX_W-1:0]     index;
    logic [hbs_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/hbs_mem.sv =====
// Single-port height memory, read-first, registered read data.
// Depends on hbs_pkg for the height width.
module hbs_mem #(
    parameter int DEPTH = 65536
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [$clog2(DEPTH)-1:0]              i_addr,
    input  logic signed [hbs_pkg::H_W-1:0]        i_wdata,
    output logic signed [hbs_pkg::H_W-1:0]        o_rdata
);

    logic signed [hbs_pkg::H_W-1:0] mem [DEPTH];
    logic signed [hbs_pkg::H_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/hbs_coord.sv =====
// World-to-grid mapping: scales X then Z on one multiplier and derives
// cell corners, their validity and the fractions. Depends on hbs_pkg.
module hbs_coord #(
    parameter int IDX_W = 8,
    parameter int LIM_W = 9
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [hbs_pkg::POS_W-1:0]   i_qx,
    input  logic signed [hbs_pkg::POS_W-1:0]   i_qz,
    input  logic [hbs_pkg::SCALE_W-1:0]        i_scale,
    input  logic [LIM_W-1:0]                   i_w_lim,
    input  logic [LIM_W-1:0]                   i_d_lim,
    output logic                               o_done,
    output hbs_pkg::t_axis                     o_x,
    output hbs_pkg::t_axis                     o_z,
    output logic [IDX_W-1:0]                   o_x_lo,
    output logic [IDX_W-1:0]                   o_x_hi,
    output logic [IDX_W-1:0]                   o_z_lo,
    output logic [IDX_W-1:0]                   o_z_hi
);

    hbs_pkg::t_cstep r_step;
    hbs_pkg::t_cstep n_step;

    logic signed [hbs_pkg::POS_W-1:0] r_qz;
    logic signed [47:0]               r_p;
    logic signed [hbs_pkg::POS_W-1:0] mul_a;
    logic signed [48:0]               mul_p;
    logic [LIM_W-1:0]                 lim;

    logic signed [23:0] lo_raw;
    logic signed [24:0] hi_raw;
    logic signed [24:0] lim_s;
    logic signed [24:0] lo_c;
    logic signed [24:0] hi_c;
    hbs_pkg::t_axis     axis;

    hbs_pkg::t_axis     r_x;
    hbs_pkg::t_axis     r_z;
    logic [IDX_W-1:0]   r_x_lo;
    logic [IDX_W-1:0]   r_x_hi;
    logic [IDX_W-1:0]   r_z_lo;
    logic [IDX_W-1:0]   r_z_hi;

    // next step
    always_comb begin
        n_step = r_step;
        case (r_step)
            hbs_pkg::CS_IDLE: if (i_start) n_step = hbs_pkg::CS_X;
            hbs_pkg::CS_X:    n_step = hbs_pkg::CS_Z;
            hbs_pkg::CS_Z:    n_step = hbs_pkg::CS_DONE;
            hbs_pkg::CS_DONE: n_step = hbs_pkg::CS_IDLE;
            default:          n_step = hbs_pkg::CS_IDLE;
        endcase
    end

    // step outputs
    always_comb begin
        mul_a  = (r_step == hbs_pkg::CS_IDLE) ? i_qx : r_qz;
        lim    = (r_step == hbs_pkg::CS_X) ? i_w_lim : i_d_lim;
        o_done = (r_step == hbs_pkg::CS_DONE);
    end

    assign mul_p = mul_a * $signed({1'b0, i_scale});

    // Corners of one axis from the scaled position in r_p (Q24.24)
    always_comb begin
        lo_raw = r_p[47:24];
        hi_raw = {lo_raw[23], lo_raw} + 25'sd1;
        lim_s  = $signed(25'(lim));
        hi_c   = (hi_raw >= lim_s) ? (lim_s - 25'sd1) : hi_raw;
        lo_c   = lo_raw[23] ? 25'sd0 : {1'b0, lo_raw};
        axis.lo_ok = (lo_c < lim_s);
        axis.hi_ok = !hi_c[24] && (hi_c < lim_s);
        // negative lower corner is pinned to 0, fraction then extrapolates
        axis.frac  = lo_raw[23] ? r_p[47:8] : $signed({24'd0, r_p[23:8]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= hbs_pkg::CS_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_step)
            hbs_pkg::CS_IDLE: begin
                if (i_start) begin
                    r_qz <= i_qz;
                    r_p  <= mul_p[47:0];
                end
            end
            hbs_pkg::CS_X: begin
                r_x    <= axis;
                r_x_lo <= lo_c[IDX_W-1:0];
                r_x_hi <= hi_c[IDX_W-1:0];
                r_p    <= mul_p[47:0];
            end
            hbs_pkg::CS_Z: begin
                r_z    <= axis;
                r_z_lo <= lo_c[IDX_W-1:0];
                r_z_hi <= hi_c[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    assign o_x    = r_x;
    assign o_z    = r_z;
    assign o_x_lo = r_x_lo;
    assign o_x_hi = r_x_hi;
    assign o_z_lo = r_z_lo;
    assign o_z_hi = r_z_hi;

endmodule

// ===== hw/rtl/hbs_blend.sv =====
// Linear blend a + (b - a) * f on one shared multiplier, fraction split in
// two partial products, rounded to Q16.8 and saturated. Depends on hbs_pkg.
module hbs_blend (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [hbs_pkg::H_W-1:0]         i_a,
    input  logic signed [hbs_pkg::H_W-1:0]         i_b,
    input  logic signed [hbs_pkg::FRAC_W-1:0]      i_f,
    output logic                                   o_done,
    output logic signed [hbs_pkg::H_W-1:0]         o_result
);

    hbs_pkg::t_bstep r_step;
    hbs_pkg::t_bstep n_step;

    logic signed [hbs_pkg::H_W-1:0]    r_a;
    logic signed [hbs_pkg::H_W:0]      r_d;
    logic signed [hbs_pkg::FRAC_W-1:0] r_f;
    logic signed [45:0]                r_prod;
    logic signed [65:0]                r_acc;
    logic signed [20:0]                mul_b;
    logic signed [45:0]                mul_p;
    logic [26:0]                       acc_top;

    always_comb begin
        n_step = r_step;
        case (r_step)
            hbs_pkg::BS_IDLE: if (i_start) n_step = hbs_pkg::BS_LO;
            hbs_pkg::BS_LO:   n_step = hbs_pkg::BS_HI;
            hbs_pkg::BS_HI:   n_step = hbs_pkg::BS_ADD;
            hbs_pkg::BS_ADD:  n_step = hbs_pkg::BS_DONE;
            hbs_pkg::BS_DONE: n_step = hbs_pkg::BS_IDLE;
            default:          n_step = hbs_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        // low 20 fraction bits unsigned first, then the signed upper part
        mul_b   = (r_step == hbs_pkg::BS_LO) ? $signed({1'b0, r_f[19:0]})
                                             : $signed({r_f[39], r_f[39:20]});
        o_done  = (r_step == hbs_pkg::BS_DONE);
        acc_top = r_acc[65:39];
        if (acc_top == '0 || acc_top == '1) begin
            o_result = r_acc[39:16];
        end else begin
            o_result = r_acc[65] ? hbs_pkg::H_MIN : hbs_pkg::H_MAX;
        end
    end

    assign mul_p = r_d * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= hbs_pkg::BS_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_step)
            hbs_pkg::BS_IDLE: begin
                if (i_start) begin
                    r_a <= i_a;
                    r_d <= {i_b[hbs_pkg::H_W-1], i_b} - {i_a[hbs_pkg::H_W-1], i_a};
                    r_f <= i_f;
                end
            end
            hbs_pkg::BS_LO: begin
                r_prod <= mul_p;
                r_acc  <= ($signed(66'(r_a)) <<< 16) + 66'sd32768;
            end
            hbs_pkg::BS_HI: begin
                r_prod <= mul_p;
                r_acc  <= r_acc + $signed(66'(r_prod));
            end
            hbs_pkg::BS_ADD: begin
                r_acc <= r_acc + ($signed(66'(r_prod)) <<< 20);
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/bilinear_height_sampler_top.sv =====
// Write item: the sample is stored in the same cycle it is accepted, unless it lies outside the store.
// Sample item: the two scale multiplies, four corner reads on the single-port height
// memory and three blends on one shared multiplier; the result is then loaded into the
// output register, and the next item is accepted after that load, which waits on a stalled output.
// Reset: control and configuration registers return to their reset values;
// height memory is not cleared and holds undefined data until written.
module bilinear_height_sampler_top #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hbs_in_if.sink    i_in_ch,
    hbs_out_if.source o_out_ch,
    hbs_cfg_if.sink   i_cfg_ch
);

    localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int LIM_W0  = $clog2(MAX_DIM + 1);
    localparam int LIM_W   = (LIM_W0 > hbs_pkg::GRID_W) ? LIM_W0 : hbs_pkg::GRID_W;
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int IDX_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int DEPTH   = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam logic [LIM_W-1:0]  COLS_L   = LIM_W'(MAX_COLS);
    localparam logic [LIM_W-1:0]  ROWS_L   = LIM_W'(MAX_ROWS);
    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MAX_COLS);

    hbs_pkg::t_state r_state;
    hbs_pkg::t_state n_state;
    hbs_pkg::t_bsel  r_bsel;

    logic [hbs_pkg::GRID_W-1:0]  r_grid_width;
    logic [hbs_pkg::GRID_W-1:0]  r_grid_depth;
    logic [hbs_pkg::SCALE_W-1:0] r_inv_scale;

    logic signed [hbs_pkg::H_W-1:0] r_h00, r_h10, r_h01, r_h11;
    logic signed [hbs_pkg::H_W-1:0] r_h0, r_h1, r_h;
    logic                           r_out_valid;
    logic signed [hbs_pkg::H_W-1:0] r_out_height;

    logic [LIM_W-1:0] w_eff;
    logic [LIM_W-1:0] d_eff;

    logic in_acc;
    logic coord_start;
    logic coord_done;
    logic blend_start;
    logic blend_done;
    logic out_load;
    logic mem_we;
    logic wr_in_range;

    hbs_pkg::t_axis   x_axis;
    hbs_pkg::t_axis   z_axis;
    logic [IDX_W-1:0] x_lo, x_hi, z_lo, z_hi;
    logic ok00, ok10, ok01, ok11;

    logic [COL_W-1:0]  acc_col;
    logic [ROW_W-1:0]  acc_row;
    logic [ADDR_W-1:0] mem_addr;
    logic signed [hbs_pkg::H_W-1:0] mem_rdata;

    logic signed [hbs_pkg::H_W-1:0]    bl_a;
    logic signed [hbs_pkg::H_W-1:0]    bl_b;
    logic signed [hbs_pkg::FRAC_W-1:0] bl_f;
    logic signed [hbs_pkg::H_W-1:0]    bl_result;

    // Configuration
    assign i_cfg_ch.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= hbs_pkg::GRID_RESET;
            r_grid_depth <= hbs_pkg::GRID_RESET;
            r_inv_scale  <= hbs_pkg::SCALE_RESET;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                hbs_pkg::CFG_GRID_WIDTH:      r_grid_width <= i_cfg_ch.data[hbs_pkg::GRID_W-1:0];
                hbs_pkg::CFG_GRID_DEPTH:      r_grid_depth <= i_cfg_ch.data[hbs_pkg::GRID_W-1:0];
                hbs_pkg::CFG_INV_WORLD_SCALE: r_inv_scale  <= i_cfg_ch.data;
                default: ;
            endcase
        end
    end

    // Grid extent in use, capped at the store size
    always_comb begin
        w_eff = (LIM_W'(r_grid_width) > COLS_L) ? COLS_L : LIM_W'(r_grid_width);
        d_eff = (LIM_W'(r_grid_depth) > ROWS_L) ? ROWS_L : LIM_W'(r_grid_depth);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hbs_pkg::ST_IDLE:   if (coord_start) n_state = hbs_pkg::ST_COORD;
            hbs_pkg::ST_COORD:  if (coord_done) n_state = hbs_pkg::ST_RD00;
            hbs_pkg::ST_RD00:   n_state = hbs_pkg::ST_RD10;
            hbs_pkg::ST_RD10:   n_state = hbs_pkg::ST_RD01;
            hbs_pkg::ST_RD01:   n_state = hbs_pkg::ST_RD11;
            hbs_pkg::ST_RD11:   n_state = hbs_pkg::ST_CAP;
            hbs_pkg::ST_CAP:    n_state = hbs_pkg::ST_BSTART;
            hbs_pkg::ST_BSTART: n_state = hbs_pkg::ST_BWAIT;
            hbs_pkg::ST_BWAIT: begin
                if (blend_done) begin
                    n_state = (r_bsel == hbs_pkg::BL_COL) ? hbs_pkg::ST_OUT
                                                          : hbs_pkg::ST_BSTART;
                end
            end
            hbs_pkg::ST_OUT:    if (out_load) n_state = hbs_pkg::ST_IDLE;
            default:            n_state = hbs_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_in_ch.ready = i_rst_n && (r_state == hbs_pkg::ST_IDLE);
        in_acc        = i_in_ch.valid && i_in_ch.ready;
        wr_in_range   = (LIM_W'(i_in_ch.write_col) < COLS_L) &&
                        (LIM_W'(i_in_ch.write_row) < ROWS_L);
        coord_start   = in_acc && (i_in_ch.operation == hbs_pkg::OP_SAMPLE);
        mem_we        = in_acc && (i_in_ch.operation == hbs_pkg::OP_WRITE) && wr_in_range;
        blend_start   = (r_state == hbs_pkg::ST_BSTART);
        out_load      = (r_state == hbs_pkg::ST_OUT) && (!r_out_valid || o_out_ch.ready);

        if (mem_we) begin
            acc_col = COL_W'(i_in_ch.write_col);
            acc_row = ROW_W'(i_in_ch.write_row);
        end else begin
            acc_col = (r_state inside {hbs_pkg::ST_RD10, hbs_pkg::ST_RD11}) ?
                      x_hi[COL_W-1:0] : x_lo[COL_W-1:0];
            acc_row = (r_state inside {hbs_pkg::ST_RD01, hbs_pkg::ST_RD11}) ?
                      z_hi[ROW_W-1:0] : z_lo[ROW_W-1:0];
        end
        mem_addr = ADDR_W'(acc_row) * ROW_STEP + ADDR_W'(acc_col);

        case (r_bsel)
            hbs_pkg::BL_ROW0: begin
                bl_a = r_h00;
                bl_b = r_h10;
                bl_f = x_axis.frac;
            end
            hbs_pkg::BL_ROW1: begin
                bl_a = r_h01;
                bl_b = r_h11;
                bl_f = x_axis.frac;
            end
            default: begin
                bl_a = r_h0;
                bl_b = r_h1;
                bl_f = z_axis.frac;
            end
        endcase
    end

    assign ok00 = x_axis.lo_ok && z_axis.lo_ok;
    assign ok10 = x_axis.hi_ok && z_axis.lo_ok;
    assign ok01 = x_axis.lo_ok && z_axis.hi_ok;
    assign ok11 = x_axis.hi_ok && z_axis.hi_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hbs_pkg::ST_IDLE;
            r_bsel      <= hbs_pkg::BL_ROW0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (coord_start) begin
                r_bsel <= hbs_pkg::BL_ROW0;
            end else if (r_state == hbs_pkg::ST_BWAIT && blend_done) begin
                case (r_bsel)
                    hbs_pkg::BL_ROW0: r_bsel <= hbs_pkg::BL_ROW1;
                    hbs_pkg::BL_ROW1: r_bsel <= hbs_pkg::BL_COL;
                    default:          r_bsel <= hbs_pkg::BL_COL;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Corner and blend capture: read data arrives in the state after its address
    always_ff @(posedge i_clk) begin
        case (r_state)
            hbs_pkg::ST_RD10: r_h00 <= ok00 ? mem_rdata : '0;
            hbs_pkg::ST_RD01: r_h10 <= ok10 ? mem_rdata : '0;
            hbs_pkg::ST_RD11: r_h01 <= ok01 ? mem_rdata : '0;
            hbs_pkg::ST_CAP:  r_h11 <= ok11 ? mem_rdata : '0;
            hbs_pkg::ST_BWAIT: begin
                if (blend_done) begin
                    case (r_bsel)
                        hbs_pkg::BL_ROW0: r_h0 <= bl_result;
                        hbs_pkg::BL_ROW1: r_h1 <= bl_result;
                        default:          r_h  <= bl_result;
                    endcase
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_height <= r_h;
        end
    end

    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.sampled_height = r_out_height;

    hbs_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_in_ch.write_height),
        .o_rdata (mem_rdata)
    );

    hbs_coord #(
        .IDX_W (IDX_W),
        .LIM_W (LIM_W)
    ) u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (coord_start),
        .i_qx    (i_in_ch.query_x),
        .i_qz    (i_in_ch.query_z),
        .i_scale (r_inv_scale),
        .i_w_lim (w_eff),
        .i_d_lim (d_eff),
        .o_done  (coord_done),
        .o_x     (x_axis),
        .o_z     (z_axis),
        .o_x_lo  (x_lo),
        .o_x_hi  (x_hi),
        .o_z_lo  (z_lo),
        .o_z_hi  (z_hi)
    );

    hbs_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (blend_start),
        .i_a      (bl_a),
        .i_b      (bl_b),
        .i_f      (bl_f),
        .o_done   (blend_done),
        .o_result (bl_result)
    );

endmodule

// ===== hw/rtl/hbs_checker.sv =====
// Port-level checks for the bilinear height sampler, bound to the top level.
// Depends on hbs_pkg and the assertion macros header.
`include "bilinear_height_sampler_top_defines.svh"

module hbs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_in_operation,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic signed [hbs_pkg::H_W-1:0] i_out_height
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    `HBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `HBS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_height))
    `HBS_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, in_acc && (i_in_operation == hbs_pkg::OP_WRITE) && !i_out_valid, !i_out_valid)
    `HBS_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, in_acc && (i_in_operation == hbs_pkg::OP_SAMPLE), !i_in_ready)

endmodule

bind bilinear_height_sampler_top hbs_checker u_hbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_ch.valid),
    .i_in_ready     (i_in_ch.ready),
    .i_in_operation (i_in_ch.operation),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_out_height   (o_out_ch.sampled_height)
);

// ===== tb/sv/tb_bilinear_height_sampler_top.sv =====
// Self-checking testbench for bilinear_height_sampler_top: a grid model predicts each
// interpolated height, and a scoreboard compares it with the block's result stream.
// Depends on hbs_pkg, the channel interfaces in hbs_if.sv and the top-level RTL.
`timescale 1ns / 1ps

module tb_bilinear_height_sampler_top;

    localparam int MAX_COLS     = 256;
    localparam int MAX_ROWS     = 256;
    localparam int GRID_ENTRIES = MAX_COLS * MAX_ROWS;
    localparam int TAIL_CYCLES  = 30;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef logic signed [79:0]                     t_wide;
    typedef logic signed [hbs_pkg::H_W-1:0]         t_height;
    typedef logic signed [hbs_pkg::POS_W-1:0]       t_pos;
    typedef logic [hbs_pkg::WIDX_W-1:0]             t_widx;
    typedef logic [hbs_pkg::CFG_IDX_W-1:0]          t_cfg_idx;
    typedef logic [hbs_pkg::CFG_DATA_W-1:0]         t_cfg_data;

    typedef struct {
        logic    op;
        t_widx   col;
        t_widx   row;
        t_height height;
        t_pos    qx;
        t_pos    qz;
    } t_hbs_item;

    // Grid model: stored heights, register copies and the queue of predicted heights.
    class t_terrain_grid;
        t_height                         heights [GRID_ENTRIES];
        bit                              written [GRID_ENTRIES];
        logic [hbs_pkg::GRID_W-1:0]      width_reg;
        logic [hbs_pkg::GRID_W-1:0]      depth_reg;
        logic [hbs_pkg::SCALE_W-1:0]     scale_reg;
        t_height                         pending_heights [$];
        int                              fails;

        function new();
            width_reg = hbs_pkg::GRID_RESET;
            depth_reg = hbs_pkg::GRID_RESET;
            scale_reg = hbs_pkg::SCALE_RESET;
            fails     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                hbs_pkg::CFG_GRID_WIDTH:      width_reg = data[hbs_pkg::GRID_W-1:0];
                hbs_pkg::CFG_GRID_DEPTH:      depth_reg = data[hbs_pkg::GRID_W-1:0];
                hbs_pkg::CFG_INV_WORLD_SCALE: scale_reg = data[hbs_pkg::SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function int cols_in_use();
            return (width_reg > MAX_COLS) ? MAX_COLS : int'(width_reg);
        endfunction

        function int rows_in_use();
            return (depth_reg > MAX_ROWS) ? MAX_ROWS : int'(depth_reg);
        endfunction

        function bit in_grid(int col, int row);
            return col >= 0 && row >= 0 && col < cols_in_use() && row < rows_in_use();
        endfunction

        function bit needs_write(int col, int row);
            return in_grid(col, row) && !written[row * MAX_COLS + col];
        endfunction

        // Scale one axis, floor to corners, clamp hi to the edge and lo at zero.
        function void locate(input t_pos q, input int lim,
                             output int c0, output int c1, output t_wide frac);
            t_wide qq, sc, p, w, lo, hi;
            qq = q;
            sc = scale_reg;
            p  = qq * sc;
            w  = p >>> 8;
            lo = p >>> 24;
            hi = lo + 1;
            if (hi >= lim) hi = lim - 1;
            if (lo < 0) lo = 0;
            c0   = int'(lo);
            c1   = int'(hi);
            frac = w - lo * 65536;
        endfunction

        function t_wide corner_height(int col, int row);
            t_wide h;
            h = 0;
            if (in_grid(col, row)) h = heights[row * MAX_COLS + col];
            return h;
        endfunction

        function t_wide blend(t_wide a, t_wide b, t_wide f);
            t_wide acc;
            acc = a * 65536 + (b - a) * f;
            acc = (acc + 32768) >>> 16;
            if (acc > hbs_pkg::H_MAX) acc = hbs_pkg::H_MAX;
            if (acc < hbs_pkg::H_MIN) acc = hbs_pkg::H_MIN;
            return acc;
        endfunction

        function t_height interp_height(t_pos qx, t_pos qz);
            int    x0, x1, z0, z1;
            t_wide fx, fz, h0, h1, h;
            locate(qx, cols_in_use(), x0, x1, fx);
            locate(qz, rows_in_use(), z0, z1, fz);
            h0 = blend(corner_height(x0, z0), corner_height(x1, z0), fx);
            h1 = blend(corner_height(x0, z1), corner_height(x1, z1), fx);
            h  = blend(h0, h1, fz);
            return h[hbs_pkg::H_W-1:0];
        endfunction

        function void record_item(t_hbs_item it);
            int idx;
            if (it.op == hbs_pkg::OP_WRITE) begin
                idx = int'(it.row) * MAX_COLS + int'(it.col);
                heights[idx] = it.height;
                written[idx] = 1'b1;
            end else begin
                pending_heights = {pending_heights, interp_height(it.qx, it.qz)};
            end
        endfunction

        function void check_height(t_height got);
            t_height want;
            if (pending_heights.size() == 0) begin
                $error("sampled_height: no result expected, got %0d", got);
                fails++;
            end else begin
                want = pending_heights.pop_front();
                if (got !== want) begin
                    $error("sampled_height: expected %0d, got %0d", want, got);
                    fails++;
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    hbs_in_if  in_ch ();
    hbs_out_if out_ch ();
    hbs_cfg_if cfg_ch ();

    bilinear_height_sampler_top #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    t_terrain_grid terrain;
    int            burst_left  = 0;
    int            stall_mode  = 0;
    int            stall_left  = 0;
    int            stall_tick  = 0;
    int unsigned   cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: switch at random between stall patterns.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= ((stall_tick & 7) == 7);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            terrain.check_height(out_ch.sampled_height);
    end

    function automatic t_height rand_height();
        case ($urandom_range(0, 5))
            0:       return hbs_pkg::H_MAX;
            1:       return hbs_pkg::H_MIN;
            2:       return '0;
            3:       return t_height'($signed($urandom_range(0, 1023)) - 512);
            default: return t_height'($urandom);
        endcase
    endfunction

    function automatic t_hbs_item scrambled_item();
        t_hbs_item it;
        it.op     = 1'($urandom);
        it.col    = t_widx'($urandom);
        it.row    = t_widx'($urandom);
        it.height = t_height'($urandom);
        it.qx     = t_pos'($urandom);
        it.qz     = t_pos'($urandom);
        return it;
    endfunction

    // Query mostly over the grid in use, some just below zero, some anywhere.
    function automatic t_pos rand_query(int lim);
        longint span, v;
        if (lim < 1) lim = 1;
        if (terrain.scale_reg == 0)
            span = 8388607;
        else
            span = ((longint'(lim) + 1) <<< 24) / longint'(terrain.scale_reg);
        if (span > 8388607) span = 8388607;
        case ($urandom_range(0, 9))
            0:       v = longint'($urandom);
            1:       v = -longint'($urandom_range(0, int'(span / 4)));
            default: v = longint'($urandom_range(0, int'(span)));
        endcase
        return v[hbs_pkg::POS_W-1:0];
    endfunction

    task automatic push_item(input t_hbs_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= it.op;
        in_ch.write_col    <= it.col;
        in_ch.write_row    <= it.row;
        in_ch.write_height <= it.height;
        in_ch.query_x      <= it.qx;
        in_ch.query_z      <= it.qz;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        terrain.record_item(it);
        @(negedge i_clk);
    endtask

    task automatic put_height(input int col, input int row, input t_height h);
        t_hbs_item it;
        it        = scrambled_item();
        it.op     = hbs_pkg::OP_WRITE;
        it.col    = t_widx'(col);
        it.row    = t_widx'(row);
        it.height = h;
        push_item(it);
    endtask

    // Fill any corner the query will read that has never been written, then sample.
    task automatic sample_at(input t_pos qx, input t_pos qz);
        int        x0, x1, z0, z1, col, row;
        t_wide     fx, fz;
        t_hbs_item it;
        terrain.locate(qx, terrain.cols_in_use(), x0, x1, fx);
        terrain.locate(qz, terrain.rows_in_use(), z0, z1, fz);
        for (int i = 0; i < 4; i++) begin
            col = i[0] ? x1 : x0;
            row = i[1] ? z1 : z0;
            if (terrain.needs_write(col, row)) put_height(col, row, rand_height());
        end
        it    = scrambled_item();
        it.op = hbs_pkg::OP_SAMPLE;
        it.qx = qx;
        it.qz = qz;
        push_item(it);
    endtask

    task automatic random_item();
        int cw, cd;
        cw = terrain.cols_in_use();
        cd = terrain.rows_in_use();
        if ($urandom_range(0, 3) == 0) begin
            put_height((cw > 0 && $urandom_range(0, 1)) ? $urandom_range(0, cw - 1)
                                                         : $urandom_range(0, 255),
                       (cd > 0 && $urandom_range(0, 1)) ? $urandom_range(0, cd - 1)
                                                         : $urandom_range(0, 255),
                       rand_height());
        end else begin
            sample_at(rand_query(cw), rand_query(cd));
        end
    endtask

    // Hold the sender until every predicted height has come back, then let the block settle.
    task automatic wait_for_heights();
        in_ch.valid <= 1'b0;
        while (terrain.pending_heights.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input t_cfg_data data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        terrain.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int w, input int d, input int scale, input int n);
        wait_for_heights();
        write_cfg(hbs_pkg::CFG_GRID_WIDTH, t_cfg_data'(w));
        write_cfg(hbs_pkg::CFG_GRID_DEPTH, t_cfg_data'(d));
        write_cfg(hbs_pkg::CFG_INV_WORLD_SCALE, t_cfg_data'(scale));
        cfg_ch.valid <= 1'b0;
        sample_at('0, '0);
        sample_at(hbs_pkg::H_MAX, hbs_pkg::H_MIN);
        sample_at(hbs_pkg::H_MIN, hbs_pkg::H_MAX);
        repeat (n) begin
            if ($urandom_range(0, 63) == 0) wait_for_heights();
            random_item();
        end
    endtask

    initial begin
        terrain             = new();
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.operation     = hbs_pkg::OP_WRITE;
        in_ch.write_col     = '0;
        in_ch.write_row     = '0;
        in_ch.write_height  = '0;
        in_ch.query_x       = '0;
        in_ch.query_z       = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = hbs_pkg::CFG_GRID_WIDTH;
        cfg_ch.data         = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: full 256 x 256 grid at unit spacing.
        put_height(0, 0, hbs_pkg::H_MAX);
        put_height(1, 0, hbs_pkg::H_MIN);
        put_height(0, 1, hbs_pkg::H_MIN);
        put_height(1, 1, hbs_pkg::H_MAX);
        put_height(255, 255, hbs_pkg::H_MIN);
        put_height(254, 255, '0);
        put_height(255, 254, 24'sh000100);
        put_height(254, 254, -24'sd1);
        put_height(255, 0, 24'sh7FFF00);
        put_height(0, 255, -24'sh0055AA);
        sample_at('0, '0);
        sample_at(24'sh000080, 24'sh000080);
        sample_at(24'sh0000FF, 24'sh000001);
        sample_at(24'sh00FF00, 24'sh00FF00);
        sample_at(24'sh00FE80, 24'sh00FE80);
        sample_at(hbs_pkg::H_MAX, hbs_pkg::H_MAX);
        sample_at(hbs_pkg::H_MIN, hbs_pkg::H_MIN);
        sample_at(-24'sh000100, 24'sh000040);
        sample_at(24'sh000040, -24'sh000180);
        wait_for_heights();
        repeat (40) random_item();

        run_phase(1, 1, 65536, 25);
        run_phase(256, 256, 0, 20);          // zero scale: every query hits corner (0,0)
        run_phase(2, 3, 24'hFFFFFF, 30);
        run_phase(17, 5, 32768, 40);
        run_phase(0, 4, 65536, 15);          // empty grid reads zero everywhere
        run_phase(511, 300, 65536, 15);      // oversized grid acts as the full store
        run_phase(8, 8, 24'h020000, 40);
        run_phase(256, 1, 1, 20);
        run_phase(1, 256, 24'h000100, 30);
        repeat (3) begin
            run_phase(($urandom_range(0, 3) == 0) ? $urandom_range(1, 256)
                                                   : $urandom_range(1, 16),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256)
                                                   : $urandom_range(1, 16),
                      ($urandom_range(0, 2) == 0) ? int'($urandom & 24'hFFFFFF)
                                                   : $urandom_range(24'h004000, 24'h040000),
                      40);
        end

        wait_for_heights();
        if (terrain.pending_heights.size() != 0) begin
            $error("sampled_height: %0d results never arrived",
                   terrain.pending_heights.size());
            terrain.fails++;
        end
        if (terrain.fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
